// ===== hw/rtl/free_list_slot_allocator_core_defines.svh =====
// Assertion macros for the slot allocator.
// Each macro takes a label, a condition, a consequence and a message.
`ifndef FREE_LIST_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define FREE_LIST_SLOT_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define FSA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FSA_ASSERT_NOW(lbl, ante, cons, msg)
`define FSA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/fsa_pkg.sv =====
`timescale 1ns / 1ps

package fsa_pkg;

    // Field widths
    localparam int OP_W     = 2;
    localparam int SLOT_W   = 8;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 9;

    // Request codes on the operation port
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STS_RANGE = 2'd2;

    // Reset value of the slot count register
    localparam logic [CNT_W-1:0] SLOT_COUNT_RESET = 9'd256;

    // Decoded command as it travels from front to back
    typedef enum logic [1:0] {
        CMD_ALLOC,
        CMD_FREE,
        CMD_INIT,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [SLOT_W-1:0] slot;
    } cmd_t;

endpackage

// ===== hw/rtl/fsa_front.sv =====
`timescale 1ns / 1ps

module fsa_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fsa_pkg::OP_W-1:0]    operation,
    input  logic [fsa_pkg::SLOT_W-1:0]  slot_index,
    input  logic                        hold,
    input  logic                        q_full,
    output logic                        busy,
    output logic                        q_push,
    output fsa_pkg::cmd_t               q_cmd
);

    logic          valid_reg;
    logic          valid_next;
    fsa_pkg::cmd_t cmd_reg;
    fsa_pkg::cmd_t cmd_dec;
    logic          accept;

    // Classify the request code
    always_comb
    begin
        cmd_dec.slot = slot_index;
        case (operation)
            fsa_pkg::OP_ALLOC: cmd_dec.kind = fsa_pkg::CMD_ALLOC;
            fsa_pkg::OP_FREE:  cmd_dec.kind = fsa_pkg::CMD_FREE;
            fsa_pkg::OP_INIT:  cmd_dec.kind = fsa_pkg::CMD_INIT;
            default:           cmd_dec.kind = fsa_pkg::CMD_NOP;
        endcase
    end

    // Holding stage: refilled in the same cycle it drains
    assign busy       = hold || (valid_reg && q_full);
    assign accept     = start && !busy;
    assign q_push     = valid_reg && !q_full;
    assign q_cmd      = cmd_reg;
    assign valid_next = accept || (valid_reg && !q_push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_dec;
        end
    end

endmodule

// ===== hw/rtl/fsa_cmd_queue.sv =====
`timescale 1ns / 1ps

module fsa_cmd_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fsa_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output fsa_pkg::cmd_t pop_cmd
);

    fsa_pkg::cmd_t entry_mem [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign pop_cmd = entry_mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/fsa_back.sv =====
`timescale 1ns / 1ps
`include "free_list_slot_allocator_core_defines.svh"

module fsa_back
#(
    parameter int MAX_SLOTS = 256
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fsa_pkg::CNT_W-1:0]     cfg_wdata,
    input  logic                          q_valid,
    input  fsa_pkg::cmd_t                 q_cmd,
    output logic                          q_pop,
    output logic                          reset_sweep,
    output logic                          done,
    output logic [fsa_pkg::SLOT_W-1:0]    granted_slot,
    output logic [fsa_pkg::STATUS_W-1:0]  status,
    output logic [fsa_pkg::CNT_W-1:0]     used_count
);

    localparam int LINK_W     = $clog2(MAX_SLOTS + 1);
    localparam int IDX_W      = $clog2(MAX_SLOTS);
    localparam int RESET_POOL = (int'(fsa_pkg::SLOT_COUNT_RESET) > MAX_SLOTS) ?
                                MAX_SLOTS : int'(fsa_pkg::SLOT_COUNT_RESET);
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(MAX_SLOTS);

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_ALLOC_RD
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [fsa_pkg::CNT_W-1:0]      slot_count_reg;
    logic [LINK_W-1:0]              pool_reg;
    logic [LINK_W-1:0]              pool_next;
    logic [LINK_W-1:0]              head_reg;
    logic [LINK_W-1:0]              head_next;
    logic [LINK_W-1:0]              used_reg;
    logic [LINK_W-1:0]              used_next;
    logic [IDX_W-1:0]               sweep_reg;
    logic [IDX_W-1:0]               sweep_next;
    logic                           reply_reg;
    logic                           reply_next;
    logic                           done_reg;
    logic                           done_next;
    logic [fsa_pkg::SLOT_W-1:0]     granted_reg;
    logic [fsa_pkg::SLOT_W-1:0]     granted_next;
    logic [fsa_pkg::STATUS_W-1:0]   status_reg;
    logic [fsa_pkg::STATUS_W-1:0]   status_next;
    logic [fsa_pkg::CNT_W-1:0]      used_out_reg;
    logic [fsa_pkg::CNT_W-1:0]      used_out_next;

    // Next-link store
    logic [LINK_W-1:0]              link_mem [MAX_SLOTS];
    logic [LINK_W-1:0]              rd_data_reg;
    logic                           mem_we;
    logic [IDX_W-1:0]               mem_waddr;
    logic [LINK_W-1:0]              mem_wdata;

    logic [31:0]                    cnt32;
    logic [31:0]                    eff32;
    logic [LINK_W-1:0]              pool_eff;
    logic [LINK_W-1:0]              sweep_succ;
    logic                           sweep_last;
    logic                           free_ok;
    logic                           head_live;
    logic [IDX_W-1:0]               head_idx;
    logic [LINK_W-1:0]              used_inc;
    logic [LINK_W-1:0]              used_dec;

    // Clamp the register into the legal pool size
    always_comb
    begin
        cnt32 = 32'(slot_count_reg);
        if (cnt32 == 32'd0)
        begin
            eff32 = 32'd1;
        end
        else if (cnt32 > 32'(MAX_SLOTS))
        begin
            eff32 = 32'(MAX_SLOTS);
        end
        else
        begin
            eff32 = cnt32;
        end
        pool_eff = LINK_W'(eff32);
    end

    // Helpers
    assign sweep_succ = LINK_W'(32'(sweep_reg) + 32'd1);
    assign sweep_last = (sweep_succ == pool_reg);
    assign free_ok    = (32'(q_cmd.slot) < 32'(pool_reg));
    assign head_live  = (32'(head_reg) < 32'(MAX_SLOTS));
    assign head_idx   = head_reg[IDX_W-1:0];
    assign used_inc   = (used_reg < pool_reg) ? LINK_W'(used_reg + LINK_W'(1)) : used_reg;
    assign used_dec   = (used_reg != '0) ? LINK_W'(used_reg - LINK_W'(1)) : used_reg;

    // Sequencer: chain sweep, request dispatch, allocate link read
    always_comb
    begin
        state_next    = state_reg;
        pool_next     = pool_reg;
        head_next     = head_reg;
        used_next     = used_reg;
        sweep_next    = sweep_reg;
        reply_next    = reply_reg;
        done_next     = 1'b0;
        granted_next  = '0;
        status_next   = fsa_pkg::STS_OK;
        used_out_next = fsa_pkg::CNT_W'(used_reg);
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = sweep_reg;
        mem_wdata     = sweep_last ? LINK_NULL : sweep_succ;

        case (state_reg)
            S_SWEEP:
            begin
                mem_we = 1'b1;
                if (sweep_last)
                begin
                    state_next    = S_IDLE;
                    reply_next    = 1'b0;
                    done_next     = reply_reg;
                    used_out_next = '0;
                end
                else
                begin
                    sweep_next = IDX_W'(32'(sweep_reg) + 32'd1);
                end
            end

            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.kind)
                        fsa_pkg::CMD_ALLOC:
                        begin
                            if (head_live)
                            begin
                                state_next = S_ALLOC_RD;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = fsa_pkg::STS_EMPTY;
                            end
                        end

                        fsa_pkg::CMD_FREE:
                        begin
                            done_next = 1'b1;
                            if (free_ok)
                            begin
                                mem_we        = 1'b1;
                                mem_waddr     = IDX_W'(q_cmd.slot);
                                mem_wdata     = head_reg;
                                head_next     = LINK_W'(q_cmd.slot);
                                used_next     = used_dec;
                                used_out_next = fsa_pkg::CNT_W'(used_dec);
                            end
                            else
                            begin
                                status_next = fsa_pkg::STS_RANGE;
                            end
                        end

                        fsa_pkg::CMD_INIT:
                        begin
                            state_next = S_SWEEP;
                            pool_next  = pool_eff;
                            sweep_next = '0;
                            head_next  = '0;
                            used_next  = '0;
                            reply_next = 1'b1;
                        end

                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_ALLOC_RD:
            begin
                state_next    = S_IDLE;
                head_next     = rd_data_reg;
                used_next     = used_inc;
                done_next     = 1'b1;
                granted_next  = fsa_pkg::SLOT_W'(head_reg);
                used_out_next = fsa_pkg::CNT_W'(used_inc);
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, configuration and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            slot_count_reg <= fsa_pkg::SLOT_COUNT_RESET;
            pool_reg       <= LINK_W'(RESET_POOL);
            head_reg       <= '0;
            used_reg       <= '0;
            sweep_reg      <= '0;
            reply_reg      <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                slot_count_reg <= cfg_wdata;
            end
            pool_reg  <= pool_next;
            head_reg  <= head_next;
            used_reg  <= used_next;
            sweep_reg <= sweep_next;
            reply_reg <= reply_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        granted_reg  <= granted_next;
        status_reg   <= status_next;
        used_out_reg <= used_out_next;
    end

    // One write port, one registered read at the head
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= link_mem[head_idx];
    end

    assign reset_sweep  = (state_reg == S_SWEEP) && !reply_reg;
    assign done         = done_reg;
    assign granted_slot = granted_reg;
    assign status       = status_reg;
    assign used_count   = used_out_reg;

    // Checks
    `FSA_ASSERT_NOW(a_head_bounded, 1'b1, head_reg <= LINK_NULL, "head link beyond null")
    `FSA_ASSERT_NOW(a_used_bounded, 1'b1, used_reg <= pool_reg, "in-use count above pool")
    `FSA_ASSERT_NEXT(a_alloc_reply, state_reg == S_ALLOC_RD, done_reg, "allocate gave no result")
    `FSA_ASSERT_NOW(a_err_no_grant, done_reg && (status_reg != fsa_pkg::STS_OK), granted_reg == '0, "slot granted on error")

endmodule

// ===== hw/rtl/free_list_slot_allocator_core.sv =====
`timescale 1ns / 1ps
// Free-list slot allocator: hands out and takes back slot indices from a pool.
// Requests: pulse start with operation and slot_index while busy is low; the
// transaction is taken at that edge. Codes: allocate, free, initialize.
// Results: one per request, in order, on granted_slot, status and used_count
// for a single cycle marked by done. The receiver has no way to hold them.
// A decoding stage and a two-entry command queue sit in front of the sequencer
// that owns the next-link memory, so requests can be taken while it works.
// The sequencer takes the next request as soon as it is back in idle: right after
// dispatch for free, unused codes and allocate on an empty pool, after a registered
// read of the head's link for allocate, and after chaining the pool one link per
// cycle for initialize.
// slot_count is written through cfg_we/cfg_wdata, by the user only while idle
// (the block does not enforce this); it takes effect at the next initialize.
// Reset: the pool is chained for min(256, MAX_SLOTS) slots by a sweep; busy stays high
// throughout and no result is produced for it.

module free_list_slot_allocator_core
#(
    parameter int MAX_SLOTS = 256
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [fsa_pkg::OP_W-1:0]      operation,
    input  logic [fsa_pkg::SLOT_W-1:0]    slot_index,
    input  logic                          cfg_we,
    input  logic [fsa_pkg::CNT_W-1:0]     cfg_wdata,
    output logic                          done,
    output logic [fsa_pkg::SLOT_W-1:0]    granted_slot,
    output logic [fsa_pkg::STATUS_W-1:0]  status,
    output logic [fsa_pkg::CNT_W-1:0]     used_count
);

    logic          hold;
    logic          q_full;
    logic          q_push;
    fsa_pkg::cmd_t push_cmd;
    logic          q_valid;
    logic          q_pop;
    fsa_pkg::cmd_t pop_cmd;

    // Request decode and holding stage
    fsa_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .operation  (operation),
        .slot_index (slot_index),
        .hold       (hold),
        .q_full     (q_full),
        .busy       (busy),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    // Command queue between the two sides
    fsa_cmd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (pop_cmd)
    );

    // Free-list sequencer and link memory
    fsa_back #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .q_valid      (q_valid),
        .q_cmd        (pop_cmd),
        .q_pop        (q_pop),
        .reset_sweep  (hold),
        .done         (done),
        .granted_slot (granted_slot),
        .status       (status),
        .used_count   (used_count)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int POOL_MAX = 256;
    localparam logic [fsa_pkg::CNT_W-1:0] LINK_END = 9'd256;
    // Spare operation code: the block must leave its state alone
    localparam logic [fsa_pkg::OP_W-1:0] OP_SPARE = 2'd3;
    localparam int SHOWN_MAX = 10;

    typedef struct packed {
        logic [fsa_pkg::OP_W-1:0]   op;
        logic [fsa_pkg::SLOT_W-1:0] slot;
    } request_t;

    typedef struct packed {
        logic [fsa_pkg::SLOT_W-1:0]   slot;
        logic [fsa_pkg::STATUS_W-1:0] sts;
        logic [fsa_pkg::CNT_W-1:0]    count;
    } grant_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [fsa_pkg::OP_W-1:0]     operation = '0;
    logic [fsa_pkg::SLOT_W-1:0]   slot_index = '0;
    logic                         cfg_we = 1'b0;
    logic [fsa_pkg::CNT_W-1:0]    cfg_wdata = '0;
    logic                         done;
    logic [fsa_pkg::SLOT_W-1:0]   granted_slot;
    logic [fsa_pkg::STATUS_W-1:0] status;
    logic [fsa_pkg::CNT_W-1:0]    used_count;

    free_list_slot_allocator_core #(
        .MAX_SLOTS(POOL_MAX)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .slot_index(slot_index),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .done(done),
        .granted_slot(granted_slot),
        .status(status),
        .used_count(used_count)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow of the allocator state
    logic [fsa_pkg::CNT_W-1:0] link_mem [POOL_MAX];
    logic [fsa_pkg::CNT_W-1:0] free_head;
    logic [fsa_pkg::CNT_W-1:0] slots_held;
    logic [fsa_pkg::CNT_W-1:0] pool_slots;
    logic [fsa_pkg::CNT_W-1:0] slot_count_reg;

    request_t pending_reqs[$];
    grant_t   awaited_grants[$];
    bit       issue_taken = 1'b0;
    int       fault_count = 0;
    int       gap_left = 0;
    int       burst_left = 0;

    // Register value as the pool sees it: zero means one, above the maximum means the maximum
    function automatic logic [fsa_pkg::CNT_W-1:0] clamp_count(
        input logic [fsa_pkg::CNT_W-1:0] v);
        if (v == '0)
            return 9'd1;
        if (v > LINK_END)
            return LINK_END;
        return v;
    endfunction

    // Chain slots 0 .. pool-1 in order; entries beyond the pool keep their old links
    function automatic void rechain_pool();
        pool_slots = clamp_count(slot_count_reg);
        for (int i = 0; i + 1 < pool_slots; i++)
            link_mem[fsa_pkg::SLOT_W'(i)] = fsa_pkg::CNT_W'(i + 1);
        link_mem[fsa_pkg::SLOT_W'(pool_slots - 9'd1)] = LINK_END;
        free_head = '0;
        slots_held = '0;
    endfunction

    // Apply one transaction to the shadow state and return the result it should give
    function automatic grant_t predict_grant(input request_t req);
        grant_t g;
        g = '0;
        case (req.op)
            fsa_pkg::OP_ALLOC:
            begin
                if (free_head < LINK_END)
                begin
                    g.slot = free_head[fsa_pkg::SLOT_W-1:0];
                    free_head = link_mem[free_head[fsa_pkg::SLOT_W-1:0]];
                    if (free_head > LINK_END)
                        free_head = LINK_END;
                    if (slots_held < pool_slots)
                        slots_held++;
                end
                else
                    g.sts = fsa_pkg::STS_EMPTY;
            end
            fsa_pkg::OP_FREE:
            begin
                if (fsa_pkg::CNT_W'(req.slot) < pool_slots)
                begin
                    link_mem[req.slot] = free_head;
                    free_head = fsa_pkg::CNT_W'(req.slot);
                    if (slots_held > 0)
                        slots_held--;
                end
                else
                    g.sts = fsa_pkg::STS_RANGE;
            end
            fsa_pkg::OP_INIT:
                rechain_pool();
            default:
                ;
        endcase
        g.count = slots_held;
        return g;
    endfunction

    // Monitor: check results, then log accepted transactions
    always @(posedge clk)
    begin
        grant_t seen;
        grant_t want;
        request_t req;
        issue_taken = 1'b0;
        if (rst_n)
        begin
            if (done)
            begin
                seen.slot = granted_slot;
                seen.sts = status;
                seen.count = used_count;
                if (awaited_grants.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= SHOWN_MAX)
                        $display("unexpected result: slot %0d status %0d count %0d",
                                 seen.slot, seen.sts, seen.count);
                end
                else
                begin
                    want = awaited_grants.pop_front();
                    if (seen !== want)
                    begin
                        fault_count++;
                        if (fault_count <= SHOWN_MAX)
                            $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     want.slot, want.sts, want.count,
                                     seen.slot, seen.sts, seen.count);
                    end
                end
            end
            if (start && !busy)
            begin
                issue_taken = 1'b1;
                req.op = operation;
                req.slot = slot_index;
                awaited_grants.push_back(predict_grant(req));
            end
        end
    end

    // Driver: bursts of requests with random gaps, held until taken
    always @(negedge clk)
    begin
        request_t req;
        if (rst_n && (!start || issue_taken))
        begin
            if (gap_left > 0 || pending_reqs.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                start <= 1'b0;
            end
            else
            begin
                req = pending_reqs.pop_front();
                start <= 1'b1;
                operation <= req.op;
                slot_index <= req.slot;
                if (burst_left == 0)
                begin
                    // now and then a long burst with no gaps at all
                    if ($urandom_range(0, 3) == 0)
                    begin
                        gap_left = 0;
                        burst_left = $urandom_range(30, 60);
                    end
                    else
                    begin
                        gap_left = $urandom_range(1, 7);
                        burst_left = $urandom_range(1, 16);
                    end
                end
                else
                    burst_left--;
            end
        end
    end

    task automatic queue_req(input logic [fsa_pkg::OP_W-1:0] op,
                             input logic [fsa_pkg::SLOT_W-1:0] slot);
        request_t req;
        req.op = op;
        req.slot = slot;
        pending_reqs.push_back(req);
    endtask

    // Wait until every transaction has been taken and answered
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || start || busy || awaited_grants.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_slot_count(input logic [fsa_pkg::CNT_W-1:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        slot_count_reg = v;
    endtask

    // Mostly well-formed alloc/free traffic, some stray frees, spare codes and re-inits
    task automatic queue_random_phase(input int n_items, input bit fill_up);
        int spare[$];
        int held[$];
        int alloc_pct;
        int roll;
        int pick;
        int pool;
        pool = clamp_count(slot_count_reg);
        alloc_pct = fill_up ? 95 : 50;
        for (int i = 0; i < n_items; i++)
        begin
            if (!fill_up && i % 40 == 39)
            begin
                case ($urandom_range(0, 2))
                    0: alloc_pct = 15;
                    1: alloc_pct = 50;
                    default: alloc_pct = 85;
                endcase
            end
            roll = $urandom_range(0, 99);
            if (i == 0 || (!fill_up && roll < 2))
            begin
                queue_req(fsa_pkg::OP_INIT, fsa_pkg::SLOT_W'($urandom_range(0, 255)));
                spare.delete();
                held.delete();
                for (int s = 0; s < pool; s++)
                    spare.push_back(s);
            end
            else if (!fill_up && roll < 5)
                queue_req(OP_SPARE, fsa_pkg::SLOT_W'($urandom_range(0, 255)));
            else if (!fill_up && roll < 15)
                // stray free of a random slot: may be out of range or a double free
                queue_req(fsa_pkg::OP_FREE, fsa_pkg::SLOT_W'($urandom_range(0, 255)));
            else if ($urandom_range(0, 99) < alloc_pct || held.size() == 0)
            begin
                queue_req(fsa_pkg::OP_ALLOC, fsa_pkg::SLOT_W'($urandom_range(0, 255)));
                if (spare.size() > 0)
                    held.push_back(spare.pop_front());
            end
            else
            begin
                pick = $urandom_range(0, held.size() - 1);
                queue_req(fsa_pkg::OP_FREE, fsa_pkg::SLOT_W'(held[pick]));
                spare.push_front(held[pick]);
                held.delete(pick);
            end
        end
    endtask

    // Stimulus
    initial
    begin
        int phase_cfg[12];
        phase_cfg = '{3, 1, 2, 5, 8, 16, 300, 0, 40, 170, 64, 256};
        phase_cfg[10] = $urandom_range(1, 256);

        slot_count_reg = fsa_pkg::SLOT_COUNT_RESET;
        for (int i = 0; i < POOL_MAX; i++)
            link_mem[fsa_pkg::SLOT_W'(i)] = LINK_END;
        rechain_pool();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait_idle();

        // Full pool from reset: pops, pushes, top index, spare code
        queue_req(fsa_pkg::OP_ALLOC, 8'hFF);
        queue_req(fsa_pkg::OP_ALLOC, 8'h00);
        queue_req(fsa_pkg::OP_FREE, 8'd0);
        queue_req(fsa_pkg::OP_ALLOC, 8'h55);
        queue_req(fsa_pkg::OP_FREE, 8'd255);
        queue_req(OP_SPARE, 8'hAA);
        queue_req(fsa_pkg::OP_ALLOC, 8'h00);
        queue_req(fsa_pkg::OP_INIT, 8'hFF);
        wait_idle();

        // Zero register acts as one slot: empty pool, range error, double free, saturation
        set_slot_count(9'd0);
        queue_req(fsa_pkg::OP_INIT, 8'h00);
        queue_req(fsa_pkg::OP_ALLOC, 8'h00);
        queue_req(fsa_pkg::OP_ALLOC, 8'h00);
        queue_req(fsa_pkg::OP_FREE, 8'd1);
        queue_req(fsa_pkg::OP_FREE, 8'd0);
        queue_req(fsa_pkg::OP_FREE, 8'd0);
        queue_req(fsa_pkg::OP_ALLOC, 8'h00);
        queue_req(fsa_pkg::OP_ALLOC, 8'h00);
        queue_req(OP_SPARE, 8'h3C);
        wait_idle();

        // Oversized register clamps to the maximum
        set_slot_count(9'h1FF);
        queue_req(fsa_pkg::OP_INIT, 8'h00);
        queue_req(fsa_pkg::OP_FREE, 8'd85);
        queue_req(fsa_pkg::OP_ALLOC, 8'h00);
        wait_idle();

        set_slot_count(9'd2);
        queue_req(fsa_pkg::OP_INIT, 8'h00);
        queue_req(fsa_pkg::OP_ALLOC, 8'h00);
        queue_req(fsa_pkg::OP_ALLOC, 8'h00);
        queue_req(fsa_pkg::OP_ALLOC, 8'h00);
        queue_req(fsa_pkg::OP_FREE, 8'd2);
        wait_idle();

        // Random phases; the last one fills the full pool to empty
        for (int p = 0; p < 12; p++)
        begin
            set_slot_count(fsa_pkg::CNT_W'(phase_cfg[p]));
            queue_random_phase(p == 11 ? 300 : 105, p == 11);
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (fault_count == 0 && awaited_grants.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
